### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion macros sampled on the rising edge of clock, disabled during reset.
// The scope that uses them provides the signals clock and reset.

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`endif

### sv/pidpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pidpf_pkg;

   // Filter coefficient in Q17.15; 1.0 means no filtering.
   localparam int FILTER_ALPHA_Q15 = 32768;

   // Widths of the data path.
   localparam int DATA_W  = 32;
   localparam int MCAND_W = 34;
   localparam int PROD_W  = MCAND_W + DATA_W;
   localparam int WIDE_W  = 53;

   // Request modes.
   localparam logic [1:0] FUNC_ERR   = 2'd0;
   localparam logic [1:0] FUNC_MEAS  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // Register indexes.
   localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [2:0] REG_INT_GAIN   = 3'd1;
   localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [2:0] REG_SEP_THRESH = 3'd3;
   localparam logic [2:0] REG_DRIVE_MIN  = 3'd4;
   localparam logic [2:0] REG_DRIVE_MAX  = 3'd5;
   localparam logic [2:0] REG_INTEG_MIN  = 3'd6;
   localparam logic [2:0] REG_INTEG_MAX  = 3'd7;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi_lim;
      logic signed [WIDE_W-1:0] lo_lim;
      hi_lim = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      lo_lim = {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
      if (v < lo_lim) begin
         sat32 = lo_lim[DATA_W-1:0];
      end else if (v > hi_lim) begin
         sat32 = hi_lim[DATA_W-1:0];
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

   // Clamp a wide signed value; the lower limit is tested first.
   function automatic logic signed [DATA_W-1:0] clamp(input logic signed [WIDE_W-1:0] v,
                                                      input logic signed [DATA_W-1:0] lo,
                                                      input logic signed [DATA_W-1:0] hi);
      logic signed [WIDE_W-1:0] lo_w;
      logic signed [WIDE_W-1:0] hi_w;
      lo_w = {{(WIDE_W-DATA_W){lo[DATA_W-1]}}, lo};
      hi_w = {{(WIDE_W-DATA_W){hi[DATA_W-1]}}, hi};
      if (v < lo_w) begin
         clamp = lo;
      end else if (v > hi_w) begin
         clamp = hi;
      end else begin
         clamp = v[DATA_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

### sv/pidpf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial signed multiplier: one bit of the multiplier per cycle.
module pidpf_mul (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [pidpf_pkg::MCAND_W-1:0]  mcand,
   input  wire logic signed [pidpf_pkg::DATA_W-1:0]   mplier,
   output logic                                       done,
   output logic signed [pidpf_pkg::PROD_W-1:0]        prod
);
   import pidpf_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [DATA_W-1:0]          mplier_ff, mplier_in;
   logic signed [PROD_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0]   addend;
   logic                       last_bit;

   // The top bit of the multiplier carries negative weight.
   always_comb begin
      last_bit  = (cnt_ff == CNT_W'(DATA_W - 1));
      addend    = '0;
      if (mplier_ff[0]) begin
         addend = last_bit ? -mcand_ff : mcand_ff;
      end
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = {{(PROD_W-MCAND_W){mcand[MCAND_W-1]}}, mcand};
         mplier_in = mplier;
         acc_in    = '0;
      end else if (busy_ff) begin
         acc_in    = acc_ff + addend;
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + CNT_W'(1);
         if (last_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and accumulator registers.
   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

### sv/pid_positional_filtered.sv
`timescale 1ns / 1ps
`default_nettype none
// Positional PID controller in Q16.16 with a filtered derivative. A request in
// mode 0 or 1 runs four products (filter, derivative, integral and proportional
// terms) one after another through a bit-serial multiplier that retires one
// multiplier bit per cycle; each product is issued and then collected. Clear
// requests and the unused mode answer in the cycle after acceptance with the last
// drive. One request is worked on at a time; the next is accepted once the result
// has been taken.
module pid_positional_filtered (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_func,
   input  wire logic signed [pidpf_pkg::DATA_W-1:0] req_error_in,
   input  wire logic signed [pidpf_pkg::DATA_W-1:0] req_measurement,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [pidpf_pkg::DATA_W-1:0]      rsp_drive,
   input  wire logic                                csr_wr_en,
   input  wire logic [2:0]                          csr_index,
   input  wire logic [pidpf_pkg::DATA_W-1:0]        csr_wdata
);
   import pidpf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                phase_ff, phase_in;
   logic [1:0]                func_ff, func_in;
   logic signed [DATA_W-1:0]  err_ff, err_in;
   logic signed [DATA_W:0]    diff_ff, diff_in;
   logic signed [WIDE_W-3:0]  dterm_ff, dterm_in;

   logic signed [DATA_W-1:0]  prop_gain_ff, int_gain_ff, deriv_gain_ff;
   logic [DATA_W-2:0]         sep_thresh_ff;
   logic signed [DATA_W-1:0]  drive_min_ff, drive_max_ff, integ_min_ff, integ_max_ff;

   logic signed [DATA_W-1:0]  integ_ff, integ_in;
   logic signed [DATA_W-1:0]  last_err_ff, last_err_in;
   logic signed [DATA_W-1:0]  last_meas_ff, last_meas_in;
   logic signed [DATA_W-1:0]  filt_ff, filt_in;
   logic signed [DATA_W-1:0]  last_drive_ff, last_drive_in;

   logic                      mul_start;
   logic                      mul_done;
   logic signed [MCAND_W-1:0] mul_a;
   logic signed [DATA_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  mul_prod;
   logic signed [WIDE_W-1:0]  prod_q15;
   logic signed [WIDE_W-1:0]  prod_q16;
   logic [DATA_W:0]           err_mag;
   logic                      separated;
   logic                      accept;
   logic signed [WIDE_W-1:0]  drive_sum;
   logic signed [DATA_W-1:0]  drive_sat;

   // Shared serial multiplier.
   pidpf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (mul_a),
      .mplier (mul_b),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_drive = last_drive_ff;
   assign accept    = req_valid && req_ready;
   assign mul_start = (state_ff == ST_ISSUE);

   // Product shifted down with rounding toward minus infinity.
   assign prod_q15 = {{(WIDE_W-PROD_W+15){mul_prod[PROD_W-1]}}, mul_prod[PROD_W-1:15]};
   assign prod_q16 = {{(WIDE_W-PROD_W+16){mul_prod[PROD_W-1]}}, mul_prod[PROD_W-1:16]};

   // Integration freezes while the error magnitude exceeds a nonzero threshold.
   always_comb begin
      err_mag   = err_ff[DATA_W-1] ? (DATA_W+1)'(0) - {err_ff[DATA_W-1], err_ff}
                                   : {err_ff[DATA_W-1], err_ff};
      separated = (sep_thresh_ff != '0) && (err_mag > {2'b00, sep_thresh_ff});
   end

   // Sum of the three terms, saturated to the word width.
   always_comb begin
      drive_sum = prod_q16
                + {{(WIDE_W-DATA_W){integ_ff[DATA_W-1]}}, integ_ff}
                + {{2{dterm_ff[WIDE_W-3]}}, dterm_ff};
      drive_sat = sat32(drive_sum);
   end

   // Operand selection for each product.
   always_comb begin
      case (phase_ff)
         2'd0: begin
            mul_a = {diff_ff[DATA_W], diff_ff} - {{2{filt_ff[DATA_W-1]}}, filt_ff};
            mul_b = DATA_W'(FILTER_ALPHA_Q15);
         end
         2'd1: begin
            mul_a = {{2{filt_ff[DATA_W-1]}}, filt_ff};
            mul_b = deriv_gain_ff;
         end
         2'd2: begin
            mul_a = {{2{err_ff[DATA_W-1]}}, err_ff};
            mul_b = int_gain_ff;
         end
         default: begin
            mul_a = {{2{err_ff[DATA_W-1]}}, err_ff};
            mul_b = prop_gain_ff;
         end
      endcase
   end

   // Sequencer and loop state update.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      func_in       = func_ff;
      err_in        = err_ff;
      diff_in       = diff_ff;
      dterm_in      = dterm_ff;
      integ_in      = integ_ff;
      last_err_in   = last_err_ff;
      last_meas_in  = last_meas_ff;
      filt_in       = filt_ff;
      last_drive_in = last_drive_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = req_func;
               err_in  = req_error_in;
               if (req_func inside {FUNC_ERR, FUNC_MEAS}) begin
                  if (req_func == FUNC_ERR) begin
                     diff_in = {req_error_in[DATA_W-1], req_error_in}
                             - {last_err_ff[DATA_W-1], last_err_ff};
                  end else begin
                     diff_in = {req_measurement[DATA_W-1], req_measurement}
                             - {last_meas_ff[DATA_W-1], last_meas_ff};
                     last_meas_in = req_measurement;
                  end
                  last_err_in = req_error_in;
                  phase_in    = 2'd0;
                  state_in    = ST_ISSUE;
               end else begin
                  if (req_func == FUNC_CLEAR) begin
                     integ_in     = '0;
                     last_err_in  = '0;
                     last_meas_in = '0;
                     filt_in      = '0;
                  end
                  state_in = ST_RESP;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done) begin
               case (phase_ff)
                  2'd0: begin
                     filt_in = sat32(prod_q15 + {{(WIDE_W-DATA_W){filt_ff[DATA_W-1]}}, filt_ff});
                  end
                  2'd1: begin
                     dterm_in = (func_ff == FUNC_MEAS) ? -prod_q16[WIDE_W-3:0]
                                                       : prod_q16[WIDE_W-3:0];
                  end
                  2'd2: begin
                     if (!separated) begin
                        integ_in = clamp(prod_q16
                                         + {{(WIDE_W-DATA_W){integ_ff[DATA_W-1]}}, integ_ff},
                                         integ_min_ff, integ_max_ff);
                     end
                  end
                  default: begin
                     last_drive_in = clamp({{(WIDE_W-DATA_W){drive_sat[DATA_W-1]}}, drive_sat},
                                           drive_min_ff, drive_max_ff);
                  end
               endcase
               if (phase_ff == 2'd3) begin
                  state_in = ST_RESP;
               end else begin
                  phase_in = phase_ff + 2'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and loop state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= 2'd0;
         integ_ff      <= '0;
         last_err_ff   <= '0;
         last_meas_ff  <= '0;
         filt_ff       <= '0;
         last_drive_ff <= '0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         integ_ff      <= integ_in;
         last_err_ff   <= last_err_in;
         last_meas_ff  <= last_meas_in;
         filt_ff       <= filt_in;
         last_drive_ff <= last_drive_in;
      end
   end

   // Request payload and intermediate terms.
   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      err_ff   <= err_in;
      diff_ff  <= diff_in;
      dterm_ff <= dterm_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         int_gain_ff   <= '0;
         deriv_gain_ff <= '0;
         sep_thresh_ff <= '0;
         drive_min_ff  <= {1'b1, {(DATA_W-1){1'b0}}};
         drive_max_ff  <= {1'b0, {(DATA_W-1){1'b1}}};
         integ_min_ff  <= {1'b1, {(DATA_W-1){1'b0}}};
         integ_max_ff  <= {1'b0, {(DATA_W-1){1'b1}}};
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            REG_INT_GAIN:   int_gain_ff   <= csr_wdata;
            REG_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            REG_SEP_THRESH: sep_thresh_ff <= csr_wdata[DATA_W-2:0];
            REG_DRIVE_MIN:  drive_min_ff  <= csr_wdata;
            REG_DRIVE_MAX:  drive_max_ff  <= csr_wdata;
            REG_INTEG_MIN:  integ_min_ff  <= csr_wdata;
            REG_INTEG_MAX:  integ_max_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### sv/pidpf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Port-level checks of the controller.
module pidpf_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic [1:0]                          req_func,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [pidpf_pkg::DATA_W-1:0] rsp_drive
);
   import pidpf_pkg::*;

   // A waiting result stays offered.
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // Only one request is in the block at a time.
   `ASSERT_SAME(a_one_at_a_time, rsp_valid, !req_ready)

   // A clear request answers next cycle with the previous drive.
   `ASSERT_NEXT(a_clear_holds_drive, req_valid && req_ready && req_func == FUNC_CLEAR,
                rsp_valid && rsp_drive == $past(rsp_drive))

   // The drive changes only as a new result is offered.
   `ASSERT_NEXT(a_drive_stable, !rsp_valid, rsp_valid || $stable(rsp_drive))

endmodule

bind pid_positional_filtered pidpf_checker u_pidpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_func  (req_func),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_drive (rsp_drive)
);
`default_nettype wire
